>>> hdl/ste_pkg.sv
// Package for the solar thermal plant Euler step core.
// Holds item, result, config and microcode types, datapath constants and the control ROM.
// No dependencies.
`default_nettype none

package ste_pkg;

  localparam int TEMP_W = 17;
  localparam int FLOW_W = 16;
  localparam int IRR_W  = 12;
  localparam int ACC_W  = 32;
  localparam int STEP_W = 4;

  localparam logic KIND_STEP = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic signed [ACC_W-1:0] ONE_DEGREE = 32'sd256;
  localparam logic signed [ACC_W-1:0] TEMP_MAX   = 32'sd65535;
  localparam logic signed [ACC_W-1:0] TEMP_MIN   = -32'sd65536;
  localparam logic [TEMP_W-1:0] TEMP_MAX_CODE = 17'h0FFFF;
  localparam logic [TEMP_W-1:0] TEMP_MIN_CODE = 17'h10000;
  localparam logic [TEMP_W-1:0] TEMP_RESET    = 17'd5120;

  // multiplier A operand sources
  localparam logic [2:0] A_SLOPE = 3'd0;
  localparam logic [2:0] A_SOLAR = 3'd1;
  localparam logic [2:0] A_LOSS  = 3'd2;
  localparam logic [2:0] A_CXFER = 3'd3;
  localparam logic [2:0] A_TXFER = 3'd4;
  localparam logic [2:0] A_EVAP  = 3'd5;
  localparam logic [2:0] A_PROD  = 3'd6;

  // multiplier B operand sources
  localparam logic [2:0] B_TANK     = 3'd0;
  localparam logic [2:0] B_IRR      = 3'd1;
  localparam logic [2:0] B_AMB_DIFF = 3'd2;
  localparam logic [2:0] B_MF       = 3'd3;
  localparam logic [2:0] B_MWF      = 3'd4;
  localparam logic [2:0] B_DIFF     = 3'd5;
  localparam logic [2:0] B_HOT      = 3'd6;

  // accumulator operations
  localparam logic [2:0] ACC_NOP   = 3'd0;
  localparam logic [2:0] ACC_INIT  = 3'd1;
  localparam logic [2:0] ACC_C_ADD = 3'd2;
  localparam logic [2:0] ACC_C_SUB = 3'd3;
  localparam logic [2:0] ACC_T_ADD = 3'd4;
  localparam logic [2:0] ACC_T_SUB = 3'd5;

  // program end kinds
  localparam logic [1:0] FIN_NONE = 2'd0;
  localparam logic [1:0] FIN_STEP = 2'd1;
  localparam logic [1:0] FIN_LOAD = 2'd2;

  localparam logic [STEP_W-1:0] STEP_LOAD = 4'd11;

  typedef struct packed {
    logic [2:0]        a_sel;
    logic [2:0]        b_sel;
    logic [2:0]        acc_op;
    logic              lim_we;
    logic              mwf_we;
    logic              jmp_load;
    logic [STEP_W-1:0] target;
    logic [1:0]        fin;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   fire;
  } ctl_t;

  typedef struct packed {
    logic [31:0] solar_gain;
    logic [31:0] loss_gain;
    logic [31:0] collector_transfer_gain;
    logic [31:0] tank_transfer_gain;
    logic [31:0] evaporator_gain;
    logic [31:0] wf_limit_offset;
    logic [31:0] wf_limit_slope;
    logic [63:0] flow_limits;
  } cfg_t;

  typedef struct packed {
    logic              kind;
    logic [FLOW_W-1:0] fluid_flow;
    logic [FLOW_W-1:0] wf_flow;
    logic [IRR_W-1:0]  irradiance;
    logic [TEMP_W-1:0] ambient_temp;
    logic [TEMP_W-1:0] cold_temp;
    logic [TEMP_W-1:0] init_tank_temp;
    logic [TEMP_W-1:0] init_collector_temp;
  } item_t;

  typedef struct packed {
    logic [TEMP_W-1:0] tank_temp;
    logic [TEMP_W-1:0] collector_temp;
    logic [FLOW_W-1:0] fluid_flow_used;
    logic [FLOW_W-1:0] wf_flow_used;
    logic              saturated;
  } res_t;

  // Control program. Except while a finishing step stalls, the product register holds the previous step's product.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      4'd0: begin
        w.a_sel = A_SLOPE; w.b_sel = B_TANK; w.acc_op = ACC_INIT;
        w.jmp_load = 1'b1; w.target = STEP_LOAD;
      end
      4'd1: begin
        w.a_sel = A_SOLAR; w.b_sel = B_IRR; w.lim_we = 1'b1;
      end
      4'd2: begin
        w.a_sel = A_LOSS; w.b_sel = B_AMB_DIFF; w.acc_op = ACC_C_ADD; w.mwf_we = 1'b1;
      end
      4'd3: begin
        w.a_sel = A_CXFER; w.b_sel = B_MF; w.acc_op = ACC_C_SUB;
      end
      4'd4: begin
        w.a_sel = A_PROD; w.b_sel = B_DIFF;
      end
      4'd5: begin
        w.a_sel = A_TXFER; w.b_sel = B_MF; w.acc_op = ACC_C_SUB;
      end
      4'd6: begin
        w.a_sel = A_PROD; w.b_sel = B_DIFF;
      end
      4'd7: begin
        w.a_sel = A_EVAP; w.b_sel = B_MWF; w.acc_op = ACC_T_ADD;
      end
      4'd8: begin
        w.a_sel = A_PROD; w.b_sel = B_HOT;
      end
      4'd9: begin
        w.acc_op = ACC_T_SUB;
      end
      4'd10: begin
        w.fin = FIN_STEP;
      end
      STEP_LOAD: begin
        w.fin = FIN_LOAD;
      end
      default: begin
        w.fin = FIN_NONE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ste_seq.sv
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on ste_pkg.
`default_nettype none

module ste_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          is_load,
  input  wire logic          out_free,
  output ste_pkg::ctl_t      ctl,
  output logic               busy
);

  logic [ste_pkg::STEP_W-1:0] step;
  ste_pkg::ucode_t            uc;
  logic                       stall;

  always_comb begin
    uc = ste_pkg::ucode_rom(step);
    // a finishing step waits until the output register can take the result
    stall = (uc.fin != ste_pkg::FIN_NONE) && !out_free;
    ctl.uc = uc;
    ctl.fire = busy && !stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end
    end else if (ctl.fire) begin
      if (uc.fin != ste_pkg::FIN_NONE) begin
        busy <= 1'b0;
        step <= '0;
      end else if (uc.jmp_load && is_load) begin
        step <= uc.target;
      end else begin
        step <= step + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/ste_dp.sv
// Datapath: shared multiplier with product register, accumulators, flow clamps,
// plant state and final floor/saturate. Driven by the control word from ste_seq.
// Depends on ste_pkg.
`default_nettype none

module ste_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ste_pkg::ctl_t ctl,
  input  wire ste_pkg::cfg_t cfg,
  input  wire ste_pkg::item_t item,
  output ste_pkg::res_t      res
);

  logic signed [54:0] prod;
  logic signed [36:0] mul_a;
  logic signed [17:0] mul_b;

  logic signed [16:0] tank;
  logic signed [16:0] coll;
  logic signed [31:0] acc_c;
  logic signed [31:0] acc_t;
  logic signed [33:0] lim;
  logic [15:0]        mf;
  logic [15:0]        mwf;

  logic [17:0]        diff;
  logic [17:0]        amb_diff;
  logic [17:0]        hot_raw;
  logic [17:0]        hot;
  logic signed [31:0] sh24;

  logic [15:0]        fmin, fmax, wmin, wmax;
  logic signed [33:0] wmin_s, wmax_s;
  logic [15:0]        safe;
  logic [15:0]        mf_next;
  logic [15:0]        mwf_next;

  logic signed [31:0] tank_floor, coll_floor;
  logic signed [31:0] tank_fl, coll_fl;
  logic               sat;
  logic [16:0]        tank_out, coll_out;

  always_comb begin
    diff     = {coll[16], coll} - {tank[16], tank};
    amb_diff = {coll[16], coll} - {item.ambient_temp[16], item.ambient_temp};
    hot_raw  = {tank[16], tank} - {item.cold_temp[16], item.cold_temp};
    hot      = hot_raw[17] ? '0 : hot_raw;
    // floor(product / 2^24)
    sh24     = {prod[54], prod[54:24]};
  end

  always_comb begin
    unique case (ctl.uc.a_sel)
      ste_pkg::A_SLOPE: mul_a = {{5{cfg.wf_limit_slope[31]}}, cfg.wf_limit_slope};
      ste_pkg::A_SOLAR: mul_a = {5'b0, cfg.solar_gain};
      ste_pkg::A_LOSS:  mul_a = {5'b0, cfg.loss_gain};
      ste_pkg::A_CXFER: mul_a = {5'b0, cfg.collector_transfer_gain};
      ste_pkg::A_TXFER: mul_a = {5'b0, cfg.tank_transfer_gain};
      ste_pkg::A_EVAP:  mul_a = {5'b0, cfg.evaporator_gain};
      // effective gain = gain * flow / 4096
      ste_pkg::A_PROD:  mul_a = {1'b0, prod[47:12]};
      default:          mul_a = '0;
    endcase
    unique case (ctl.uc.b_sel)
      ste_pkg::B_TANK:     mul_b = {tank[16], tank};
      ste_pkg::B_IRR:      mul_b = {6'b0, item.irradiance};
      ste_pkg::B_AMB_DIFF: mul_b = amb_diff;
      ste_pkg::B_MF:       mul_b = {2'b0, mf};
      ste_pkg::B_MWF:      mul_b = {2'b0, mwf};
      ste_pkg::B_DIFF:     mul_b = diff;
      ste_pkg::B_HOT:      mul_b = hot;
      default:             mul_b = '0;
    endcase
  end

  always_comb begin
    fmin   = cfg.flow_limits[15:0];
    fmax   = cfg.flow_limits[31:16];
    wmin   = cfg.flow_limits[47:32];
    wmax   = cfg.flow_limits[63:48];
    wmin_s = {18'b0, wmin};
    wmax_s = {18'b0, wmax};

    if (item.fluid_flow < fmin)      mf_next = fmin;
    else if (item.fluid_flow > fmax) mf_next = fmax;
    else                             mf_next = item.fluid_flow;

    // pressure limit bounded to the wf range, then used as the upper clamp
    if (lim < wmin_s)      safe = wmin;
    else if (lim > wmax_s) safe = wmax;
    else                   safe = lim[15:0];

    if (item.wf_flow < wmin)      mwf_next = wmin;
    else if (item.wf_flow > safe) mwf_next = safe;
    else                          mwf_next = item.wf_flow;
  end

  always_comb begin
    tank_floor = {{15{item.cold_temp[16]}}, item.cold_temp} + ste_pkg::ONE_DEGREE;
    coll_floor = {{15{item.ambient_temp[16]}}, item.ambient_temp};
    tank_fl    = (acc_t < tank_floor) ? tank_floor : acc_t;
    coll_fl    = (acc_c < coll_floor) ? coll_floor : acc_c;
    sat = (tank_fl > ste_pkg::TEMP_MAX) || (tank_fl < ste_pkg::TEMP_MIN) ||
          (coll_fl > ste_pkg::TEMP_MAX) || (coll_fl < ste_pkg::TEMP_MIN);

    if (tank_fl > ste_pkg::TEMP_MAX)      tank_out = ste_pkg::TEMP_MAX_CODE;
    else if (tank_fl < ste_pkg::TEMP_MIN) tank_out = ste_pkg::TEMP_MIN_CODE;
    else                                  tank_out = tank_fl[16:0];
    if (coll_fl > ste_pkg::TEMP_MAX)      coll_out = ste_pkg::TEMP_MAX_CODE;
    else if (coll_fl < ste_pkg::TEMP_MIN) coll_out = ste_pkg::TEMP_MIN_CODE;
    else                                  coll_out = coll_fl[16:0];

    if (ctl.uc.fin == ste_pkg::FIN_LOAD) begin
      res.tank_temp       = item.init_tank_temp;
      res.collector_temp  = item.init_collector_temp;
      res.fluid_flow_used = '0;
      res.wf_flow_used    = '0;
      res.saturated       = 1'b0;
    end else begin
      res.tank_temp       = tank_out;
      res.collector_temp  = coll_out;
      res.fluid_flow_used = mf;
      res.wf_flow_used    = mwf;
      res.saturated       = sat;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ctl.fire) begin
      case (ctl.uc.acc_op)
        ste_pkg::ACC_INIT: begin
          acc_c <= {{15{coll[16]}}, coll};
          acc_t <= {{15{tank[16]}}, tank};
          mf    <= mf_next;
        end
        ste_pkg::ACC_C_ADD: acc_c <= acc_c + sh24;
        ste_pkg::ACC_C_SUB: acc_c <= acc_c - sh24;
        ste_pkg::ACC_T_ADD: acc_t <= acc_t + sh24;
        ste_pkg::ACC_T_SUB: acc_t <= acc_t - sh24;
        default: begin
        end
      endcase
      if (ctl.uc.lim_we) begin
        lim <= {{2{cfg.wf_limit_offset[31]}}, cfg.wf_limit_offset} - {prod[48], prod[48:16]};
      end
      if (ctl.uc.mwf_we) begin
        mwf <= mwf_next;
      end
    end
  end

  // plant state
  always_ff @(posedge clk) begin
    if (rst) begin
      tank <= ste_pkg::TEMP_RESET;
      coll <= ste_pkg::TEMP_RESET;
    end else if (ctl.fire && ctl.uc.fin != ste_pkg::FIN_NONE) begin
      tank <= res.tank_temp;
      coll <= res.collector_temp;
    end
  end

endmodule

`default_nettype wire

>>> hdl/solar_thermal_plant_euler_step_core.sv
// Solar thermal plant Euler step core: top level with APB registers, stream ports,
// input capture and output register. Depends on ste_pkg, ste_seq and ste_dp.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser is the item
//   kind: step (0) advances the plant one Euler step, load (1) sets both
//   temperatures. Each item gives exactly one result on m_tvalid/m_tready/m_tdata.
//   Timing: a step item runs an 11-step microprogram on one shared multiplier
//   (one product per cycle); a load item runs two steps. s_tready is low while
//   a program runs, so the next item is accepted only once the current one ends.
//   The result sits in an output register; the next item is accepted while it
//   waits. If m_tready stays low, the finishing step of the next item holds
//   until the register frees, and s_tready stays low meanwhile.
//   Reset: both temperatures return to 20 degrees C, registers to their defaults,
//   no result pending. Registers are written over APB at 8*index; the user must
//   write them only while idle, as the block itself does not enforce it.
`default_nettype none

module solar_thermal_plant_euler_step_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  // input items
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // fluid_flow[15:0], wf_flow[31:16], irradiance[43:32], ambient_temp[60:44],
  // cold_temp[77:61], init_tank_temp[94:78], init_collector_temp[111:95]
  input  wire logic [111:0] s_tdata,
  // kind[0]
  input  wire logic         s_tuser,
  // results
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // tank_temp[16:0], collector_temp[33:17], fluid_flow_used[49:34],
  // wf_flow_used[65:50], saturated[66], zero[71:67]
  output logic [71:0]       m_tdata
);

  localparam logic [2:0] REG_SOLAR_GAIN  = 3'd0;
  localparam logic [2:0] REG_LOSS_GAIN   = 3'd1;
  localparam logic [2:0] REG_CXFER_GAIN  = 3'd2;
  localparam logic [2:0] REG_TXFER_GAIN  = 3'd3;
  localparam logic [2:0] REG_EVAP_GAIN   = 3'd4;
  localparam logic [2:0] REG_WF_OFFSET   = 3'd5;
  localparam logic [2:0] REG_WF_SLOPE    = 3'd6;
  localparam logic [2:0] REG_FLOW_LIMITS = 3'd7;

  localparam logic [31:0] WF_OFFSET_RESET   = 32'd65535;
  localparam logic [63:0] FLOW_LIMITS_RESET = 64'hFFFF_0000_FFFF_0000;

  ste_pkg::cfg_t  cfg;
  ste_pkg::item_t item;
  ste_pkg::res_t  res;
  ste_pkg::res_t  res_q;
  ste_pkg::ctl_t  ctl;
  logic           busy;
  logic           start;
  logic           out_free;
  logic           res_load;
  logic           wr;
  logic [2:0]     reg_idx;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[5:3];
  assign wr       = psel && penable && pwrite && pready;
  assign s_tready = !busy;
  assign start    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign res_load = ctl.fire && (ctl.uc.fin != ste_pkg::FIN_NONE);
  assign m_tdata  = {5'b0, res_q.saturated, res_q.wf_flow_used, res_q.fluid_flow_used,
                     res_q.collector_temp, res_q.tank_temp};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.solar_gain              <= '0;
      cfg.loss_gain               <= '0;
      cfg.collector_transfer_gain <= '0;
      cfg.tank_transfer_gain      <= '0;
      cfg.evaporator_gain         <= '0;
      cfg.wf_limit_offset         <= WF_OFFSET_RESET;
      cfg.wf_limit_slope          <= '0;
      cfg.flow_limits             <= FLOW_LIMITS_RESET;
    end else if (wr) begin
      unique case (reg_idx)
        REG_SOLAR_GAIN:  cfg.solar_gain              <= pwdata[31:0];
        REG_LOSS_GAIN:   cfg.loss_gain               <= pwdata[31:0];
        REG_CXFER_GAIN:  cfg.collector_transfer_gain <= pwdata[31:0];
        REG_TXFER_GAIN:  cfg.tank_transfer_gain      <= pwdata[31:0];
        REG_EVAP_GAIN:   cfg.evaporator_gain         <= pwdata[31:0];
        REG_WF_OFFSET:   cfg.wf_limit_offset         <= pwdata[31:0];
        REG_WF_SLOPE:    cfg.wf_limit_slope          <= pwdata[31:0];
        REG_FLOW_LIMITS: cfg.flow_limits             <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SOLAR_GAIN:  prdata = {32'b0, cfg.solar_gain};
      REG_LOSS_GAIN:   prdata = {32'b0, cfg.loss_gain};
      REG_CXFER_GAIN:  prdata = {32'b0, cfg.collector_transfer_gain};
      REG_TXFER_GAIN:  prdata = {32'b0, cfg.tank_transfer_gain};
      REG_EVAP_GAIN:   prdata = {32'b0, cfg.evaporator_gain};
      REG_WF_OFFSET:   prdata = {32'b0, cfg.wf_limit_offset};
      REG_WF_SLOPE:    prdata = {32'b0, cfg.wf_limit_slope};
      REG_FLOW_LIMITS: prdata = cfg.flow_limits;
      default:         prdata = '0;
    endcase
  end

  // input capture; held for the whole program
  always_ff @(posedge clk) begin
    if (start) begin
      item.kind                <= s_tuser;
      item.fluid_flow          <= s_tdata[15:0];
      item.wf_flow             <= s_tdata[31:16];
      item.irradiance          <= s_tdata[43:32];
      item.ambient_temp        <= s_tdata[60:44];
      item.cold_temp           <= s_tdata[77:61];
      item.init_tank_temp      <= s_tdata[94:78];
      item.init_collector_temp <= s_tdata[111:95];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  ste_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .is_load  (item.kind == ste_pkg::KIND_LOAD),
    .out_free (out_free),
    .ctl      (ctl),
    .busy     (busy)
  );

  ste_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .cfg  (cfg),
    .item (item),
    .res  (res)
  );

endmodule

`default_nettype wire
